@@ design/assert_macros.svh @@
// Assertion macros shared by dwc_step and the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the following clock cycle.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/dwc_pkg.sv @@
// Package: types, codes and reset values of the door winch controller.
package dwc_pkg;

    localparam int PRESCALE_DEF = 4;
    localparam int CFG_AW       = 5;

    // Mode codes
    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_MAN  = 2'd1;
    localparam logic [1:0] MODE_ERR  = 2'd2;

    // Motor command codes
    localparam logic [1:0] MOT_STOP = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_DOWN = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_DIST_THR    = 3'd0;
    localparam logic [2:0] REG_OPEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MIN_CLOSED  = 3'd2;
    localparam logic [2:0] REG_PROB_WINDOW = 3'd3;
    localparam logic [2:0] REG_PROB_ERROR  = 3'd4;
    localparam logic [2:0] REG_RETRY_WAIT  = 3'd5;
    localparam logic [2:0] REG_DEB_HOLD    = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_DIST_THR    = 8'd200;
    localparam logic [14:0] RST_OPEN_HEIGHT = 15'd200;
    localparam logic [15:0] RST_MIN_CLOSED  = 16'd625;
    localparam logic [15:0] RST_PROB_WINDOW = 16'd2500;
    localparam logic [7:0]  RST_PROB_ERROR  = 8'd2;
    localparam logic [15:0] RST_RETRY_WAIT  = 16'd625;
    localparam logic [3:0]  RST_DEB_HOLD    = 4'd3;

    typedef struct packed {
        logic [7:0]  distance_threshold;
        logic [14:0] open_height;
        logic [15:0] min_closed_ticks;
        logic [15:0] problem_window_ticks;
        logic [7:0]  stall_limit;
        logic [15:0] retry_wait_ticks;
        logic [3:0]  debounce_hold;
    } t_cfg;

    typedef struct packed {
        logic       motor_stall;
        logic [7:0] distance;
        logic [3:0] buttons_raw;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  buttons_clean;
        logic        rotation_pulse;
        logic [15:0] door_height;
        logic [1:0]  motor_command;
        logic [1:0]  mode;
        logic        acted;
    } t_res;

endpackage

@@ design/dwc_cfg.sv @@
// Configuration register file with an APB-style port.
module dwc_cfg
    import dwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_threshold   <= RST_DIST_THR;
            r_cfg.open_height          <= RST_OPEN_HEIGHT;
            r_cfg.min_closed_ticks     <= RST_MIN_CLOSED;
            r_cfg.problem_window_ticks <= RST_PROB_WINDOW;
            r_cfg.stall_limit          <= RST_PROB_ERROR;
            r_cfg.retry_wait_ticks     <= RST_RETRY_WAIT;
            r_cfg.debounce_hold        <= RST_DEB_HOLD;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DIST_THR:    r_cfg.distance_threshold   <= pwdata[7:0];
                REG_OPEN_HEIGHT: r_cfg.open_height          <= pwdata[14:0];
                REG_MIN_CLOSED:  r_cfg.min_closed_ticks     <= pwdata[15:0];
                REG_PROB_WINDOW: r_cfg.problem_window_ticks <= pwdata[15:0];
                REG_PROB_ERROR:  r_cfg.stall_limit          <= pwdata[7:0];
                REG_RETRY_WAIT:  r_cfg.retry_wait_ticks     <= pwdata[15:0];
                REG_DEB_HOLD:    r_cfg.debounce_hold        <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_DIST_THR:    prdata = {24'd0, r_cfg.distance_threshold};
            REG_OPEN_HEIGHT: prdata = {17'd0, r_cfg.open_height};
            REG_MIN_CLOSED:  prdata = {16'd0, r_cfg.min_closed_ticks};
            REG_PROB_WINDOW: prdata = {16'd0, r_cfg.problem_window_ticks};
            REG_PROB_ERROR:  prdata = {24'd0, r_cfg.stall_limit};
            REG_RETRY_WAIT:  prdata = {16'd0, r_cfg.retry_wait_ticks};
            REG_DEB_HOLD:    prdata = {28'd0, r_cfg.debounce_hold};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

@@ design/dwc_step.sv @@
// Controller state and the single-pass update for one timer tick.
module dwc_step
    import dwc_pkg::*;
#(
    parameter int PRESCALE = PRESCALE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_cfg     i_cfg,
    input  t_in_item i_item,
    output t_res     o_res
);

`include "assert_macros.svh"

    localparam int PW = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
    localparam logic [PW-1:0] PRE_LAST = PW'(PRESCALE - 1);

    // State registers
    logic [PW-1:0] r_pre;
    logic [15:0]   r_tick, r_retry, r_height, r_last_pres, r_prob_start;
    logic [3:0]    r_deb;
    logic [3:0]    r_hold [4];
    logic [1:0]    r_mode, r_motor;
    logic          r_prev_rot;
    logic [7:0]    r_prob_cnt;

    // Next values
    logic [PW-1:0] n_pre;
    logic [15:0]   n_tick, n_retry, n_height, n_last_pres, n_prob_start;
    logic [3:0]    n_deb;
    logic [3:0]    n_hold [4];
    logic [1:0]    n_mode, n_motor;
    logic          n_prev_rot;
    logic [7:0]    n_prob_cnt;

    logic          act_tick, acted, pulse;
    logic [15:0]   since_pres, since_prob;
    logic [7:0]    cnt_inc;

    // Tick update
    always_comb begin
        n_pre        = r_pre;
        n_tick       = r_tick;
        n_retry      = r_retry;
        n_height     = r_height;
        n_last_pres  = r_last_pres;
        n_prob_start = r_prob_start;
        n_deb        = r_deb;
        n_hold       = r_hold;
        n_mode       = r_mode;
        n_motor      = r_motor;
        n_prev_rot   = r_prev_rot;
        n_prob_cnt   = r_prob_cnt;
        acted        = 1'b0;
        pulse        = 1'b0;
        since_pres   = 16'd0;
        since_prob   = 16'd0;
        cnt_inc      = 8'd0;

        act_tick = (r_pre == PRE_LAST);
        n_pre    = act_tick ? '0 : r_pre + PW'(1);

        if (act_tick) begin
            n_tick = r_tick + 16'd1;
            if (r_retry != 16'd0) begin
                n_retry = r_retry - 16'd1;
            end else begin
                acted = 1'b1;

                // button debounce: sample, then hold off for a while
                for (int i = 0; i < 4; i++) begin
                    if (r_hold[i] != 4'd0) begin
                        n_hold[i] = r_hold[i] - 4'd1;
                    end else begin
                        n_deb[i]  = i_item.buttons_raw[i];
                        n_hold[i] = i_cfg.debounce_hold;
                    end
                end

                // mode select; error sticks unless manual enable is on
                if (n_deb[1]) begin
                    n_mode = MODE_MAN;
                end else if (r_mode != MODE_ERR) begin
                    n_mode = MODE_AUTO;
                end

                // height count on rotation rising edge
                pulse      = n_deb[0] & ~r_prev_rot;
                n_prev_rot = n_deb[0];
                if (pulse) begin
                    n_height = (r_motor == MOT_UP) ? r_height + 16'd1 : r_height - 16'd1;
                end

                if (n_mode == MODE_MAN) begin
                    // manual drive from up/down buttons
                    case ({n_deb[3], n_deb[2]})
                        2'b11: begin
                            n_motor  = MOT_STOP;
                            n_height = 16'd0;
                        end
                        2'b01:   n_motor = MOT_UP;
                        2'b10:   n_motor = MOT_DOWN;
                        default: n_motor = MOT_STOP;
                    endcase
                end else if (n_mode != MODE_ERR) begin
                    // automatic: close while animal near, reopen after hold time
                    if (i_item.distance < i_cfg.distance_threshold) begin
                        n_last_pres = n_tick;
                    end
                    since_pres = n_tick - n_last_pres;
                    if (since_pres <= i_cfg.min_closed_ticks) begin
                        n_motor = ($signed(n_height) > 16'sd0) ? MOT_DOWN : MOT_STOP;
                    end else begin
                        n_motor = ($signed(n_height) < $signed({1'b0, i_cfg.open_height}))
                                  ? MOT_UP : MOT_STOP;
                    end

                    // dismiss stall count after the window
                    since_prob = n_tick - r_prob_start;
                    if (r_prob_cnt != 8'd0 && since_prob > i_cfg.problem_window_ticks) begin
                        n_prob_cnt = 8'd0;
                    end

                    // stall handling
                    if (i_item.motor_stall && n_motor != MOT_STOP) begin
                        n_motor = MOT_STOP;
                        if (n_prob_cnt == 8'd0) begin
                            n_prob_start = n_tick;
                        end
                        cnt_inc    = n_prob_cnt + 8'd1;
                        n_prob_cnt = cnt_inc;
                        if (cnt_inc == i_cfg.stall_limit) begin
                            n_mode = MODE_ERR;
                        end else begin
                            n_retry = i_cfg.retry_wait_ticks;
                        end
                    end
                end
            end
        end
    end

    // Result of this tick
    assign o_res.acted          = acted;
    assign o_res.mode           = n_mode;
    assign o_res.motor_command  = n_motor;
    assign o_res.door_height    = n_height;
    assign o_res.rotation_pulse = pulse;
    assign o_res.buttons_clean  = n_deb;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre        <= '0;
            r_tick       <= 16'd0;
            r_retry      <= 16'd0;
            r_height     <= 16'd0;
            r_last_pres  <= 16'd0;
            r_prob_start <= 16'd0;
            r_deb        <= 4'd0;
            r_hold       <= '{default: 4'd0};
            r_mode       <= MODE_AUTO;
            r_motor      <= MOT_STOP;
            r_prev_rot   <= 1'b0;
            r_prob_cnt   <= 8'd0;
        end else if (i_en) begin
            r_pre        <= n_pre;
            r_tick       <= n_tick;
            r_retry      <= n_retry;
            r_height     <= n_height;
            r_last_pres  <= n_last_pres;
            r_prob_start <= n_prob_start;
            r_deb        <= n_deb;
            r_hold       <= n_hold;
            r_mode       <= n_mode;
            r_motor      <= n_motor;
            r_prev_rot   <= n_prev_rot;
            r_prob_cnt   <= n_prob_cnt;
        end
    end

    // A paused tick leaves the debounced levels and mode alone
    `AST_NEXT(a_pause_holds, i_en && act_tick && r_retry != 0, $stable(r_deb) && $stable(r_mode))
    // Starting a retry pause only happens on a stall in automatic mode
    `AST_NEXT(a_retry_from_stall, i_en && r_retry == 16'd0 && n_retry != 16'd0, r_motor == MOT_STOP)

endmodule

@@ design/door_winch_controller_top.sv @@
// Top level of the door winch controller: stream ports, input and result registers.
//
// Each slave-side transfer is one timer tick; every PRESCALE-th tick acts on the door
// unless a retry wait is still counting down. The block takes one tick per clock cycle
// while the master side does not stall and returns one result per tick: the tick is
// held in an input register, the controller state is updated in one pass of compare and
// count logic, and the result lands in an output register that keeps its value while the
// master side stalls. Configuration goes through the APB-style port at byte address 4*i
// and should be written only while no tick is in flight.
module door_winch_controller_top
    import dwc_pkg::*;
#(
    parameter int PRESCALE = PRESCALE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave-side stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [15:0]       i_s_tdata,  // buttons_raw[3:0], distance[11:4], motor_stall[12]
    // master-side stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,  // acted[0], mode[2:1], motor_command[4:3],
                                          // door_height[20:5], rotation_pulse[21],
                                          // buttons_clean[25:22]
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

`include "assert_macros.svh"

    t_cfg     cfg;
    t_in_item r_in_item;
    logic     r_in_valid;
    t_res     step_res;
    t_res     r_out;
    logic     r_out_valid;
    logic     advance;

    dwc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dwc_step #(
        .PRESCALE (PRESCALE)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_cfg   (cfg),
        .i_item  (r_in_item),
        .o_res   (step_res)
    );

    // Tick moves on when the result register is free or being drained;
    // no transfer is taken while reset is held
    assign advance    = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = i_rst_n & (~r_in_valid | advance);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item <= t_in_item'(i_s_tdata[12:0]);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out};

    // A held tick with a stalled result blocks the input
    `AST_IMPL(a_stall_blocks, r_in_valid && r_out_valid && !i_m_tready, !o_s_tready)
    // Every processed tick shows up as a pending result
    `AST_NEXT(a_advance_fills, advance, r_out_valid)

endmodule
